// ===== rtl/ota_pkg.sv =====
// ota_pkg: shared types and constants for the two-level overtemp alarm
// no dependencies; imported by every module of the block

package ota_pkg;

  localparam int TEMP_W  = 12;
  localparam int TIMER_W = 16;
  localparam int LEVEL_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PRE    = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ALARM  = 2'd2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_PRE_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_DLY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_DLY = 2'd3;

  localparam logic signed [TEMP_W-1:0] PRE_THR_RST   = 12'sd480;
  localparam logic signed [TEMP_W-1:0] ALARM_THR_RST = 12'sd640;
  localparam logic [TIMER_W-1:0]       PRE_DLY_RST   = 16'd3000;
  localparam logic [TIMER_W-1:0]       ALARM_DLY_RST = 16'd5000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     clear_alarm;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               level_changed;
  } out_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] prealarm_threshold;
    logic signed [TEMP_W-1:0] alarm_threshold;
    logic [TIMER_W-1:0]       prealarm_delay_ms;
    logic [TIMER_W-1:0]       alarm_delay_ms;
  } cfg_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
    sat_inc = (t == TIMER_MAX) ? t : t + 16'd1;
  endfunction

endpackage

// ===== rtl/two_level_overtemp_alarm.sv =====
// two_level_overtemp_alarm: top level with input and result registers
// depends on ota_pkg, ota_cfg, ota_core
//
//   channel | signals                          | payload
//   in      | in_valid / in_ready              | in_data (temperature, clear_alarm)
//   out     | out_valid / out_ready            | out_data (level, level_changed)
//   cfg     | cfg_we, cfg_index                | cfg_data
//
// one transaction per cycle sustained while out_ready is high; input, then result register
// the input register and the result register each hold one transaction
// evaluation runs when the input register is full and the result register can take it
// rst is synchronous: level normal, timers stopped, valids cleared, config at its reset values
// a stalled result holds; the input register takes one more transaction, then in_ready falls

module two_level_overtemp_alarm import ota_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  logic      step;
  out_item_t result;

  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  ota_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ota_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/ota_cfg.sv =====
// ota_cfg: configuration register file of the overtemp alarm
// depends on ota_pkg

module ota_cfg import ota_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prealarm_threshold <= PRE_THR_RST;
      cfg.alarm_threshold    <= ALARM_THR_RST;
      cfg.prealarm_delay_ms  <= PRE_DLY_RST;
      cfg.alarm_delay_ms     <= ALARM_DLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRE_THR:   cfg.prealarm_threshold <= signed'(cfg_data[TEMP_W-1:0]);
        REG_ALARM_THR: cfg.alarm_threshold    <= signed'(cfg_data[TEMP_W-1:0]);
        REG_PRE_DLY:   cfg.prealarm_delay_ms  <= cfg_data[TIMER_W-1:0];
        REG_ALARM_DLY: cfg.alarm_delay_ms     <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ota_core.sv =====
// ota_core: level state, persistence timers and per-tick evaluation
// depends on ota_pkg

module ota_core import ota_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic [LEVEL_W-1:0] level, level_next;
  logic [TIMER_W-1:0] low_timer, low_timer_next;
  logic               low_run, low_run_next;
  logic [TIMER_W-1:0] high_timer, high_timer_next;
  logic               high_run, high_run_next;

  always_comb begin
    logic entered;
    logic [LEVEL_W-1:0] lvl;
    entered         = 1'b0;
    lvl             = level;
    low_timer_next  = low_timer;
    low_run_next    = low_run;
    high_timer_next = high_timer;
    high_run_next   = high_run;

    if (item.clear_alarm && level == LVL_ALARM) begin
      lvl = LVL_NORMAL;
    end

    if (lvl == LVL_ALARM) begin
      if (high_run) begin
        high_timer_next = sat_inc(high_timer);
      end
    end else begin
      if (item.temperature >= cfg.alarm_threshold) begin
        high_timer_next = high_run ? sat_inc(high_timer) : '0;
        high_run_next   = 1'b1;
        if (high_timer_next >= cfg.alarm_delay_ms) begin
          lvl            = LVL_ALARM;
          low_timer_next = '0;
          low_run_next   = 1'b0;
          entered        = 1'b1;
        end
      end else begin
        high_timer_next = '0;
        high_run_next   = 1'b0;
      end
      if (!entered) begin
        if (item.temperature >= cfg.prealarm_threshold) begin
          low_timer_next = low_run ? sat_inc(low_timer) : '0;
          low_run_next   = 1'b1;
          if (low_timer_next >= cfg.prealarm_delay_ms) begin
            lvl = LVL_PRE;
          end
        end else begin
          low_timer_next  = '0;
          low_run_next    = 1'b0;
          high_timer_next = '0;
          high_run_next   = 1'b0;
          if (lvl == LVL_PRE) begin
            lvl = LVL_NORMAL;
          end
        end
      end
    end

    level_next           = lvl;
    result.level         = lvl;
    result.level_changed = (lvl != level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= LVL_NORMAL;
      low_timer  <= '0;
      low_run    <= 1'b0;
      high_timer <= '0;
      high_run   <= 1'b0;
    end else if (step) begin
      level      <= level_next;
      low_timer  <= low_timer_next;
      low_run    <= low_run_next;
      high_timer <= high_timer_next;
      high_run   <= high_run_next;
    end
  end

endmodule

// ===== rtl/ota_checker.sv =====
// ota_checker: port-level checks of the overtemp alarm, bound to the top level
// depends on ota_pkg and two_level_overtemp_alarm

module ota_checker import ota_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic [LEVEL_W-1:0] last_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= LVL_NORMAL;
    end else if (out_valid && out_ready) begin
      last_level <= out_data.level;
    end
  end

  a_level_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.level == LVL_NORMAL || out_data.level == LVL_PRE ||
                   out_data.level == LVL_ALARM))
    else $error("undefined level code");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.level_changed == (out_data.level != last_level)))
    else $error("level_changed disagrees with previous transaction");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind two_level_overtemp_alarm ota_checker u_ota_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
